### rtl/core/accept_header_json_matcher_unit_defines.svh
// Assertion helpers shared by the matcher RTL.
`ifndef ACCEPT_HEADER_JSON_MATCHER_UNIT_DEFINES_SVH
`define ACCEPT_HEADER_JSON_MATCHER_UNIT_DEFINES_SVH

// Plain property, checked every clock edge outside reset.
`define AHJM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define AHJM_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AHJM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ahjm_pkg.sv
package ahjm_pkg;

  localparam int unsigned TargetLen = 16;
  localparam int unsigned MatchW    = 5;

  typedef enum logic [3:0] {
    PH_LEAD     = 4'd0,
    PH_MEDIA    = 4'd1,
    PH_MEDIA_WS = 4'd2,
    PH_SKIP     = 4'd3,
    PH_P_LEAD   = 4'd4,
    PH_P_Q      = 4'd5,
    PH_P_OTHER  = 4'd6,
    PH_P_SKIP   = 4'd7,
    PH_VALUE    = 4'd8
  } range_phase_e;

  typedef enum logic [2:0] {
    VZ_LEAD  = 3'd0,
    VZ_FIRST = 3'd1,
    VZ_MORE  = 3'd2,
    VZ_TAIL  = 3'd3,
    VZ_BAD   = 3'd4
  } value_phase_e;

  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChLowQ  = 8'h71;
  localparam logic [7:0] ChUpQ   = 8'h51;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] CaseOfs = 8'h20;

  // "application/json"
  localparam logic [7:0] TargetType [TargetLen] = '{
    8'h61, 8'h70, 8'h70, 8'h6C, 8'h69, 8'h63, 8'h61, 8'h74,
    8'h69, 8'h6F, 8'h6E, 8'h2F, 8'h6A, 8'h73, 8'h6F, 8'h6E
  };

  function automatic logic is_ws(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic value_is_zero(value_phase_e v);
    return (v == VZ_FIRST) || (v == VZ_MORE) || (v == VZ_TAIL);
  endfunction

endpackage

### rtl/core/accept_header_json_matcher_unit.sv
// Accept-header JSON matcher. Feed the bytes of one HTTP Accept header value
// as beats on the input channel, one byte per beat, with last_char_i set on
// the final byte. Ranges split on ',', parameters on ';'; blanks and tabs
// are trimmed, case is ignored. For each header exactly one output beat
// comes back, accepts_json_o = 1 when some range is application/json with
// a first q parameter that is absent or nonzero. Headers may follow each
// other with no gap. Throughput is one byte per cycle: the per-byte parse
// update is a single small state step between the input register and the
// state/result registers. The last byte's result passes through the input
// register and then the result register. A pending result that is not taken
// stalls input only when the next header's last byte reaches the parse stage.
`include "accept_header_json_matcher_unit_defines.svh"

module accept_header_json_matcher_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] header_char_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       accepts_json_o
);
  import ahjm_pkg::*;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  // result register
  logic       out_valid_q, out_valid_d;
  logic       out_data_q;

  logic       out_free;   // result register can take a beat this cycle
  logic       s1_adv;     // input register hands its byte to the parser
  logic       in_fire;
  logic       parse_result;

  assign out_free   = !out_valid_q || out_ready_i;
  // non-last bytes never need the result register
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire)     s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_last_q) out_valid_d = 1'b1;
    else if (out_ready_i)    out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= header_char_i;
      s1_last_q <= last_char_i;
    end
    if (s1_adv && s1_last_q) begin
      out_data_q <= parse_result;
    end
  end

  ahjm_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (s1_adv),
    .char_i   (s1_char_q),
    .last_i   (s1_last_q),
    .result_o (parse_result)
  );

  assign out_valid_o    = out_valid_q;
  assign accepts_json_o = out_data_q;

  `AHJM_ASSERT_IMPL(a_out_from_last, clk_i, rst_ni, $rose(out_valid_q), $past(s1_valid_q && s1_last_q), "result beat without a last byte")
  `AHJM_ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_char_q) && $stable(s1_last_q), "stalled byte lost")
  `AHJM_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_o, s1_valid_q && s1_last_q && out_valid_q && !out_ready_i, "input stalled without a blocked result")

endmodule

### rtl/core/ahjm_parser.sv
`include "accept_header_json_matcher_unit_defines.svh"

module ahjm_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output logic       result_o
);
  import ahjm_pkg::*;

  range_phase_e        range_phase_q, range_phase_d, ph_t;
  value_phase_e        value_phase_q, value_phase_d, vz_t;
  logic [MatchW-1:0]   match_count_q, match_count_d, mc_t;
  logic                found_q, found_d, fm_t;
  logic                comma, close_range, counts;
  logic [7:0]          lc;
  logic                hit;

  assign comma       = (char_i == ChComma);
  assign close_range = comma || last_i;
  assign lc          = ((char_i >= ChUpA) && (char_i <= ChUpZ)) ? char_i + CaseOfs : char_i;
  assign hit         = !match_count_q[MatchW-1] &&
                       (lc == TargetType[match_count_q[MatchW-2:0]]);

  // effect of one byte on the range state (comma leaves it for the close step)
  always_comb begin
    ph_t = range_phase_q;
    vz_t = value_phase_q;
    mc_t = match_count_q;
    fm_t = found_q;
    if (!comma) begin
      case (range_phase_q)
        PH_LEAD: begin
          if (char_i == ChSemi) ph_t = PH_SKIP;
          else if (!is_ws(char_i)) begin
            if (hit) begin
              mc_t = match_count_q + MatchW'(1);
              ph_t = PH_MEDIA;
            end else ph_t = PH_SKIP;
          end
        end
        PH_MEDIA, PH_MEDIA_WS: begin
          if (char_i == ChSemi)
            ph_t = (match_count_q == MatchW'(TargetLen)) ? PH_P_LEAD : PH_SKIP;
          else if (is_ws(char_i)) ph_t = PH_MEDIA_WS;
          else if (range_phase_q == PH_MEDIA_WS) ph_t = PH_SKIP;
          else if (hit) begin
            mc_t = match_count_q + MatchW'(1);
            ph_t = PH_MEDIA;
          end else ph_t = PH_SKIP;
        end
        PH_SKIP: ph_t = PH_SKIP;
        PH_P_LEAD: begin
          if ((char_i == ChSemi) || is_ws(char_i)) ph_t = PH_P_LEAD;
          else if ((char_i == ChLowQ) || (char_i == ChUpQ)) ph_t = PH_P_Q;
          else if (char_i == ChEq) ph_t = PH_P_SKIP;
          else ph_t = PH_P_OTHER;
        end
        PH_P_Q: begin
          if (char_i == ChSemi) ph_t = PH_P_LEAD;
          else if (char_i == ChEq) begin
            ph_t = PH_VALUE;
            vz_t = VZ_LEAD;
          end else if (!is_ws(char_i)) ph_t = PH_P_OTHER;
        end
        PH_P_OTHER: begin
          if (char_i == ChSemi) ph_t = PH_P_LEAD;
          else if (char_i == ChEq) ph_t = PH_P_SKIP;
        end
        PH_P_SKIP: begin
          if (char_i == ChSemi) ph_t = PH_P_LEAD;
        end
        PH_VALUE: begin
          if (char_i == ChSemi) begin
            if (!value_is_zero(value_phase_q)) fm_t = 1'b1;
            ph_t = PH_SKIP;
          end else begin
            case (value_phase_q)
              VZ_LEAD: begin
                if (char_i == ChZero) vz_t = VZ_FIRST;
                else if (!is_ws(char_i)) vz_t = VZ_BAD;
              end
              VZ_FIRST: begin
                if ((char_i == ChDot) || (char_i == ChZero)) vz_t = VZ_MORE;
                else if (is_ws(char_i)) vz_t = VZ_TAIL;
                else vz_t = VZ_BAD;
              end
              VZ_MORE: begin
                if (char_i == ChZero) vz_t = VZ_MORE;
                else if (is_ws(char_i)) vz_t = VZ_TAIL;
                else vz_t = VZ_BAD;
              end
              VZ_TAIL: begin
                if (!is_ws(char_i)) vz_t = VZ_BAD;
              end
              default: vz_t = VZ_BAD;
            endcase
          end
        end
        default: ph_t = PH_SKIP;
      endcase
    end
  end

  // does the range being closed count
  always_comb begin
    case (ph_t)
      PH_LEAD, PH_MEDIA, PH_MEDIA_WS: counts = (mc_t == MatchW'(TargetLen));
      PH_P_LEAD, PH_P_Q, PH_P_OTHER, PH_P_SKIP: counts = 1'b1;
      PH_VALUE: counts = !value_is_zero(vz_t);
      default: counts = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    range_phase_d = range_phase_q;
    value_phase_d = value_phase_q;
    match_count_d = match_count_q;
    found_d       = found_q;
    if (take_i) begin
      range_phase_d = ph_t;
      value_phase_d = vz_t;
      match_count_d = mc_t;
      found_d       = fm_t;
      if (close_range) begin
        range_phase_d = PH_LEAD;
        value_phase_d = VZ_LEAD;
        match_count_d = '0;
        found_d       = fm_t || counts;
      end
      if (last_i) found_d = 1'b0;
    end
  end

  // output
  always_comb begin
    result_o = fm_t || (close_range && counts);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_phase_q <= PH_LEAD;
      value_phase_q <= VZ_LEAD;
      match_count_q <= '0;
      found_q       <= 1'b0;
    end else begin
      range_phase_q <= range_phase_d;
      value_phase_q <= value_phase_d;
      match_count_q <= match_count_d;
      found_q       <= found_d;
    end
  end

  `AHJM_ASSERT(a_match_count_range, clk_i, rst_ni, match_count_q <= MatchW'(TargetLen), "match count past target length")
  `AHJM_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, take_i && last_i, (range_phase_q == PH_LEAD) && (match_count_q == '0) && !found_q, "state not cleared after last beat")
  `AHJM_ASSERT_NEXT(a_found_sticky, clk_i, rst_ni, found_q && take_i && !last_i, found_q, "match flag lost inside header")

endmodule
